// ===== rtl/stereo_mixer_with_agc_defines.svh =====
// Assertion macros for the stereo mixer with gain control.
`ifndef STEREO_MIXER_WITH_AGC_DEFINES_SVH
`define STEREO_MIXER_WITH_AGC_DEFINES_SVH
`ifndef ASSERT_OFF
`define SMA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mixer assertion failed");
`define SMA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("mixer assertion failed");
`else
`define SMA_ASSERT(label, clk, rst, prop)
`define SMA_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/smagc_pkg.sv =====
`timescale 1ns / 1ps
package smagc_pkg;

  localparam int SMP_W   = 16;
  localparam int MAX_CH  = 8;
  localparam int SV_W    = 25;
  localparam int PROD_W  = 34;
  localparam int SUM_W   = 37;
  localparam int MIX_W   = 20;
  localparam int PEAK_W  = 19;
  localparam int GAIN_W  = 17;
  localparam int QUO_W   = 16;
  localparam int IDX_W   = 8;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
  localparam logic [PEAK_W-1:0] NUM_HI   = 19'd32767;

  localparam logic [IDX_W-1:0] REG_VOLUMES = 8'd0;
  localparam logic [IDX_W-1:0] REG_PAN_LO  = 8'd1;
  localparam logic [IDX_W-1:0] REG_PAN_HI  = 8'd2;
  localparam logic [IDX_W-1:0] REG_MUTE    = 8'd3;
  localparam logic [IDX_W-1:0] REG_MASTER  = 8'd4;
  localparam logic [IDX_W-1:0] REG_AGC     = 8'd5;

  typedef struct packed {
    logic signed [15:0] chan0_sample;
    logic signed [15:0] chan1_sample;
    logic signed [15:0] chan2_sample;
    logic signed [15:0] chan3_sample;
    logic signed [15:0] chan4_sample;
    logic signed [15:0] chan5_sample;
    logic signed [15:0] chan6_sample;
    logic signed [15:0] chan7_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic [16:0]        gain_now;
    logic               over_range;
  } out_item_t;

  typedef struct packed {
    logic [7:0] vol;
    logic [8:0] pan;
    logic       mute;
  } lane_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/stereo_mixer_with_agc.sv =====
`timescale 1ns / 1ps
// Stereo mixer with automatic gain control.
// Input channel (in_valid / in_stall / in_data): one frame of eight signed
// 16-bit samples per transaction. Output channel (out_valid / out_stall /
// out_data): one left/right pair, the gain used and the over-range flag.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
// writes; cfg_ready is always high, so issue writes only while idle.
// Frames are handled one at a time. From the input transaction, the frame
// passes the lane A, lane B, sum, master, truncate, peak, update, gain,
// product and output states before out_valid rises; when AGC is on and the
// mix is over range, a divide state after peak waits for the divider's 16
// quotient steps and its done flag.
// A new frame is accepted only after the result enters the output register.
// The result sits in an output register; a stalled receiver holds it and
// the block may take and work on the next frame meanwhile, then waits
// before overwriting. in_stall is high whenever a frame is in flight.
// Reset (rst, synchronous) loads register defaults and unity gain and
// empties the output register.
`include "stereo_mixer_with_agc_defines.svh"
module stereo_mixer_with_agc #(
  parameter int CHANNELS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  smagc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output smagc_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [smagc_pkg::IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_LANE_A = 12'b000000000010,
    ST_LANE_B = 12'b000000000100,
    ST_SUM    = 12'b000000001000,
    ST_MAST   = 12'b000000010000,
    ST_TRUNC  = 12'b000000100000,
    ST_PEAK   = 12'b000001000000,
    ST_DIV    = 12'b000010000000,
    ST_UPD    = 12'b000100000000,
    ST_GAIN   = 12'b001000000000,
    ST_PROD   = 12'b010000000000,
    ST_OUT    = 12'b100000000000
  } state_t;

  localparam int MFULL_W = smagc_pkg::SUM_W + 9;
  localparam int PL_W    = smagc_pkg::MIX_W + 18;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [63:0] volumes;
  logic [35:0] pan_lo;
  logic [35:0] pan_hi;
  logic [7:0]  mute;
  logic [7:0]  master;
  logic        agc_en;

  logic [smagc_pkg::GAIN_W-1:0] gain;
  smagc_pkg::in_item_t          frame;

  logic signed [smagc_pkg::SMP_W-1:0] samp [smagc_pkg::MAX_CH];
  logic signed [smagc_pkg::PROD_W-1:0] lane_l [CHANNELS];
  logic signed [smagc_pkg::PROD_W-1:0] lane_r [CHANNELS];

  logic signed [smagc_pkg::SUM_W-1:0] sum_l_c, sum_r_c, sum_l, sum_r;
  logic signed [MFULL_W-1:0] mfull_l, mfull_r;
  logic signed [MFULL_W-1:0] mrnd_l, mrnd_r;
  logic signed [smagc_pkg::MIX_W-1:0] ml, mr;
  logic [smagc_pkg::MIX_W-1:0] abs_l, abs_r;
  logic [smagc_pkg::PEAK_W-1:0] peak_c;
  logic over_c, over;
  logic [smagc_pkg::GAIN_W-1:0] target;
  logic signed [35:0] delta;
  logic signed [17:0] diff;
  logic signed [17:0] gain_step;
  logic signed [PL_W-1:0] pl, pr;
  logic signed [PL_W-1:0] prnd_l, prnd_r;
  logic signed [21:0] gl, gr;
  logic [7:0] master_sat;

  logic div_start;
  smagc_pkg::div_stat_t div_stat;
  logic [smagc_pkg::QUO_W-1:0] quotient;

  logic in_acc, out_take, out_load;

  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    if (v > 22'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -22'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign out_load  = (state == ST_OUT) && (!out_valid || !out_stall);

  assign samp[0] = frame.chan0_sample;
  assign samp[1] = frame.chan1_sample;
  assign samp[2] = frame.chan2_sample;
  assign samp[3] = frame.chan3_sample;
  assign samp[4] = frame.chan4_sample;
  assign samp[5] = frame.chan5_sample;
  assign samp[6] = frame.chan6_sample;
  assign samp[7] = frame.chan7_sample;

  // channel lanes
  for (genvar n = 0; n < CHANNELS; n++) begin : g_lane
    smagc_pkg::lane_cfg_t lcfg;
    assign lcfg.vol  = volumes[8*n +: 8];
    assign lcfg.pan  = (n < 4) ? pan_lo[9*(n%4) +: 9] : pan_hi[9*(n%4) +: 9];
    assign lcfg.mute = mute[n];
    smagc_lane u_lane (
      .clk    (clk),
      .sample (samp[n]),
      .cfg    (lcfg),
      .prod_l (lane_l[n]),
      .prod_r (lane_r[n])
    );
  end

  // merge: side sums over lanes
  always_comb begin
    sum_l_c = '0;
    sum_r_c = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      sum_l_c = sum_l_c + smagc_pkg::SUM_W'(lane_l[i]);
      sum_r_c = sum_r_c + smagc_pkg::SUM_W'(lane_r[i]);
    end
  end

  assign master_sat = (master > 8'd128) ? 8'd128 : master;

  // truncate toward zero on divide by 2^21
  assign mrnd_l = mfull_l + (mfull_l[MFULL_W-1] ? MFULL_W'(21'h1FFFFF) : '0);
  assign mrnd_r = mfull_r + (mfull_r[MFULL_W-1] ? MFULL_W'(21'h1FFFFF) : '0);

  assign abs_l  = ml[smagc_pkg::MIX_W-1] ? -ml : ml;
  assign abs_r  = mr[smagc_pkg::MIX_W-1] ? -mr : mr;
  assign peak_c = (abs_r > abs_l) ? abs_r[smagc_pkg::PEAK_W-1:0]
                                  : abs_l[smagc_pkg::PEAK_W-1:0];
  assign over_c = (peak_c > 19'd32767);
  assign div_start = (state == ST_PEAK) && agc_en && over_c;

  assign diff      = $signed({1'b0, target}) - $signed({1'b0, gain});
  assign gain_step = delta[33:16];  // floor divide by 2^16

  assign prnd_l = pl + (pl[PL_W-1] ? PL_W'(16'hFFFF) : '0);
  assign prnd_r = pr + (pr[PL_W-1] ? PL_W'(16'hFFFF) : '0);
  assign gl = prnd_l[37:16];
  assign gr = prnd_r[37:16];

  smagc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (peak_c),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_acc) state_next = ST_LANE_A;
      ST_LANE_A: state_next = ST_LANE_B;
      ST_LANE_B: state_next = ST_SUM;
      ST_SUM:    state_next = ST_MAST;
      ST_MAST:   state_next = ST_TRUNC;
      ST_TRUNC:  state_next = ST_PEAK;
      ST_PEAK:   state_next = div_start ? ST_DIV : ST_UPD;
      ST_DIV:    if (div_stat.done) state_next = ST_UPD;
      ST_UPD:    state_next = ST_GAIN;
      ST_GAIN:   state_next = ST_PROD;
      ST_PROD:   state_next = ST_OUT;
      ST_OUT:    if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control and config
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      volumes   <= 64'h8080808080808080;
      pan_lo    <= '0;
      pan_hi    <= '0;
      mute      <= '0;
      master    <= 8'd128;
      agc_en    <= 1'b1;
      gain      <= smagc_pkg::GAIN_ONE;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          smagc_pkg::REG_VOLUMES: volumes <= cfg_data;
          smagc_pkg::REG_PAN_LO:  pan_lo  <= cfg_data[35:0];
          smagc_pkg::REG_PAN_HI:  pan_hi  <= cfg_data[35:0];
          smagc_pkg::REG_MUTE:    mute    <= cfg_data[7:0];
          smagc_pkg::REG_MASTER:  master  <= cfg_data[7:0];
          smagc_pkg::REG_AGC: begin
            agc_en <= cfg_data[0];
            if (cfg_data[0]) gain <= smagc_pkg::GAIN_ONE;
          end
          default: ;
        endcase
      end
      if (state == ST_GAIN && agc_en) begin
        gain <= smagc_pkg::GAIN_W'($signed({1'b0, gain}) + gain_step);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) frame <= in_data;
    if (state == ST_SUM) begin
      sum_l <= sum_l_c;
      sum_r <= sum_r_c;
    end
    if (state == ST_MAST) begin
      mfull_l <= sum_l * $signed({1'b0, master_sat});
      mfull_r <= sum_r * $signed({1'b0, master_sat});
    end
    if (state == ST_TRUNC) begin
      ml <= mrnd_l[smagc_pkg::MIX_W+20:21];
      mr <= mrnd_r[smagc_pkg::MIX_W+20:21];
    end
    if (state == ST_PEAK) begin
      over   <= over_c;
      target <= smagc_pkg::GAIN_ONE;
    end
    if (state == ST_DIV && div_stat.done) begin
      target <= {1'b0, quotient};
    end
    if (state == ST_UPD) delta <= diff * 18'sd655;
    if (state == ST_PROD) begin
      pl <= ml * $signed({1'b0, gain});
      pr <= mr * $signed({1'b0, gain});
    end
    if (out_load) begin
      out_data.over_range <= over;
      if (agc_en) begin
        out_data.left_out  <= sat16(gl);
        out_data.right_out <= sat16(gr);
        out_data.gain_now  <= gain;
      end else begin
        out_data.left_out  <= sat16(22'(ml));
        out_data.right_out <= sat16(22'(mr));
        out_data.gain_now  <= smagc_pkg::GAIN_ONE;
      end
    end
  end

  `SMA_ASSERT(a_gain_range, clk, rst, gain <= smagc_pkg::GAIN_ONE)
  `SMA_ASSERT(a_div_in_state, clk, rst, !div_stat.busy || state == ST_DIV)
  `SMA_ASSERT(a_busy_after_acc, clk, rst, in_acc |=> in_stall)

endmodule

// ===== rtl/smagc_lane.sv =====
`timescale 1ns / 1ps
// One channel: volume, then pan weights for both sides. Two register stages.
module smagc_lane (
  input  logic                               clk,
  input  logic signed [smagc_pkg::SMP_W-1:0] sample,
  input  smagc_pkg::lane_cfg_t               cfg,
  output logic signed [smagc_pkg::PROD_W-1:0] prod_l,
  output logic signed [smagc_pkg::PROD_W-1:0] prod_r
);

  logic [7:0]              vol_sat;
  logic signed [8:0]       pan_sat;
  logic signed [8:0]       wl;
  logic signed [8:0]       wr;
  logic signed [smagc_pkg::SV_W-1:0] sv;
  logic signed [8:0]       wl_q;
  logic signed [8:0]       wr_q;

  always_comb begin
    vol_sat = (cfg.vol > 8'd128) ? 8'd128 : cfg.vol;
    if ($signed(cfg.pan) > 9'sd128) begin
      pan_sat = 9'sd128;
    end else if ($signed(cfg.pan) < -9'sd128) begin
      pan_sat = -9'sd128;
    end else begin
      pan_sat = $signed(cfg.pan);
    end
    if (pan_sat <= 9'sd0) begin
      wl = 9'sd128;
      wr = 9'sd128 + pan_sat;
    end else begin
      wl = 9'sd128 - pan_sat;
      wr = 9'sd128;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg.mute) begin
      sv <= '0;
    end else begin
      sv <= sample * $signed({1'b0, vol_sat});
    end
    wl_q   <= wl;
    wr_q   <= wr;
    prod_l <= sv * wl_q;
    prod_r <= sv * wr_q;
  end

endmodule

// ===== rtl/smagc_div.sv =====
`timescale 1ns / 1ps
// Restoring divide of 32767*2^16 by the peak, one quotient bit per cycle.
// Quotient fits 16 bits since the divisor is above 32767.
module smagc_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [smagc_pkg::PEAK_W-1:0]      divisor,
  output smagc_pkg::div_stat_t              stat,
  output logic [smagc_pkg::QUO_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(smagc_pkg::QUO_W + 1);

  logic [smagc_pkg::PEAK_W:0]   rem;
  logic [smagc_pkg::PEAK_W-1:0] dvs;
  logic [CNT_W-1:0]             cnt;
  logic                         busy;
  logic                         done;
  logic [smagc_pkg::PEAK_W+1:0] trial;

  assign trial = {rem, 1'b0} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(smagc_pkg::QUO_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, smagc_pkg::NUM_HI};
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      if (!trial[smagc_pkg::PEAK_W+1]) begin
        rem      <= trial[smagc_pkg::PEAK_W:0];
        quotient <= {quotient[smagc_pkg::QUO_W-2:0], 1'b1};
      end else begin
        rem      <= {rem[smagc_pkg::PEAK_W-1:0], 1'b0};
        quotient <= {quotient[smagc_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
